[rtl/core/ucd_pkg.sv]
// ----------------------------------------------------------------------------
// ucd_pkg: shared constants for the timestamp to calendar converter
// Day offsets, Gregorian cycle lengths, cumulative month tables and latency.
// ----------------------------------------------------------------------------
package ucd_pkg;

	// Day-of-year values run 0..365
	typedef logic [8:0] doy_t;

	// Days from 0001-01-01 to 1970-01-01
	localparam int unsigned DAY_OFFSET = 719162;

	// Gregorian cycle lengths in days
	localparam int unsigned DAYS_400Y = 146097;
	localparam int unsigned DAYS_100Y = 36524;
	localparam int unsigned DAYS_4Y   = 1461;
	localparam int unsigned DAYS_1Y   = 365;

	// Seconds of day split: day = 2^7 * 675, hour = 2^4 * 225, minute = 2^2 * 15
	localparam int unsigned DAY_ODD  = 675;
	localparam int unsigned HOUR_ODD = 225;
	localparam int unsigned MIN_ODD  = 15;

	// Days in front of each month, common year then leap year
	localparam doy_t CUM_DAYS [2][13] = '{
		'{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		  9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
		'{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		  9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
	};

	// Cycles from input acceptance to output register
	localparam int unsigned PIPE_LAT = 18;

endpackage

[rtl/core/unix_time_to_calendar_date_core.sv]
// ----------------------------------------------------------------------------
// unix_time_to_calendar_date_core: seconds since 1970 to UTC date and time
// Converts a 40-bit epoch second count into year, month, day, hour, minute
// and second of the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one word per timestamp, s_tdata[39:0] = seconds.
//   Output stream m_*: one word per timestamp, same order, fields packed
//   from the low bit up (see the m_tdata port).
//   Throughput is one word per cycle when nothing stalls. The pipeline is
//   the chain of constant dividers (86400, then 400/100/4/1-year cycles,
//   with hour and minute in parallel), three stages each, plus one rebase
//   stage and two stages for the month lookup and the output register.
//   All stages move together: when m_tvalid is high and m_tready low, the
//   whole pipeline holds and s_tready drops; nothing is lost or repeated.
//   Reset clears the valid bits only; the pipeline comes up empty.
//   No state carries from one word to the next.
// ----------------------------------------------------------------------------
module unix_time_to_calendar_date_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [39:0] seconds_since_epoch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // year, month, day_of_month, hour, minute, second
);

	import ucd_pkg::*;

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	// day split
	logic [23:0] days_a;
	logic [9:0]  rdh_a;
	logic [6:0]  rdl_a;
	logic [23:0] z_s4;
	logic [16:0] rd_s4;

	// 400-year cycles
	logic [6:0]  n400_b;
	logic [17:0] r400_b;
	logic [16:0] rd_b;

	// 100-year cycles and hour
	logic [2:0]  n100_c;
	logic [15:0] r100_c;
	logic [6:0]  n400_c;
	logic [4:0]  hour_c;
	logic [7:0]  rhh_c;
	logic [3:0]  rhl_c;
	logic [11:0] remh_c;

	// 4-year cycles and minute
	logic [4:0]  n4_d;
	logic [10:0] r4_d;
	logic [8:0]  yhi_d;
	logic [8:0]  yhi_d_o;
	logic [5:0]  min_d;
	logic [3:0]  rm_d;
	logic [6:0]  hsl_d;
	logic [5:0]  sec_d;

	// single years
	logic [2:0]  n1_e;
	logic [8:0]  doy_e;
	logic [30:0] side_e;
	logic [6:0]  n400_e;
	logic [1:0]  n100_e;
	logic [4:0]  n4_e;
	logic [4:0]  hour_e;
	logic [5:0]  min_e;
	logic [5:0]  sec_e;
	logic [1:0]  n1_w;
	logic        leap_e;
	logic [3:0]  mon_e;

	// month lookup and output
	logic        leap_s17;
	logic [3:0]  mon_s17;
	doy_t        doy_s17;
	logic [15:0] ysum_s17;
	logic [6:0]  ytail_s17;
	logic [4:0]  hour_s17;
	logic [5:0]  min_s17;
	logic [5:0]  sec_s17;
	logic [15:0] year_s18;
	logic [3:0]  month_s18;
	logic [4:0]  day_s18;
	logic [4:0]  hour_s18;
	logic [5:0]  min_s18;
	logic [5:0]  sec_s18;

	// global advance: move when the output slot is free or being taken
	assign en       = !vld_q[PIPE_LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	// seconds / 86400 as (seconds >> 7) / 675
	ucd_divc #(
		.IN_W(33), .DIV(DAY_ODD), .Q_W(24), .R_W(10), .CAP(16777215), .SIDE_W(7)
	) u_div_day (
		.clk(clk), .en(en), .x(s_tdata[39:7]), .side_in(s_tdata[6:0]),
		.q(days_a), .r(rdh_a), .side_out(rdl_a)
	);

	// rebase day count to 0001-01-01
	always_ff @(posedge clk) begin
		if (en) begin
			z_s4  <= days_a + 24'(DAY_OFFSET);
			rd_s4 <= {rdh_a, rdl_a};
		end
	end

	ucd_divc #(
		.IN_W(24), .DIV(DAYS_400Y), .Q_W(7), .R_W(18), .CAP(127), .SIDE_W(17)
	) u_div_400 (
		.clk(clk), .en(en), .x(z_s4), .side_in(rd_s4),
		.q(n400_b), .r(r400_b), .side_out(rd_b)
	);

	// last day of a 400-year cycle stays in century 3
	ucd_divc #(
		.IN_W(18), .DIV(DAYS_100Y), .Q_W(3), .R_W(16), .CAP(3), .SIDE_W(7)
	) u_div_100 (
		.clk(clk), .en(en), .x(r400_b), .side_in(n400_b),
		.q(n100_c), .r(r100_c), .side_out(n400_c)
	);

	// hour = (sec_of_day >> 4) / 225
	ucd_divc #(
		.IN_W(13), .DIV(HOUR_ODD), .Q_W(5), .R_W(8), .CAP(31), .SIDE_W(4)
	) u_div_hour (
		.clk(clk), .en(en), .x(rd_b[16:4]), .side_in(rd_b[3:0]),
		.q(hour_c), .r(rhh_c), .side_out(rhl_c)
	);

	assign remh_c = {rhh_c, rhl_c};
	assign yhi_d  = {n400_c, n100_c[1:0]};

	ucd_divc #(
		.IN_W(16), .DIV(DAYS_4Y), .Q_W(5), .R_W(11), .CAP(31), .SIDE_W(9)
	) u_div_4 (
		.clk(clk), .en(en), .x(r100_c), .side_in(yhi_d),
		.q(n4_d), .r(r4_d), .side_out(yhi_d_o)
	);

	// minute = (sec_of_hour >> 2) / 15
	ucd_divc #(
		.IN_W(10), .DIV(MIN_ODD), .Q_W(6), .R_W(4), .CAP(63), .SIDE_W(7)
	) u_div_min (
		.clk(clk), .en(en), .x(remh_c[11:2]), .side_in({hour_c, remh_c[1:0]}),
		.q(min_d), .r(rm_d), .side_out(hsl_d)
	);

	assign sec_d = {rm_d, hsl_d[1:0]};

	// last day of a 4-year cycle stays in year 3
	ucd_divc #(
		.IN_W(11), .DIV(DAYS_1Y), .Q_W(3), .R_W(9), .CAP(3), .SIDE_W(31)
	) u_div_1 (
		.clk(clk), .en(en), .x(r4_d),
		.side_in({yhi_d_o, n4_d, hsl_d[6:2], min_d, sec_d}),
		.q(n1_e), .r(doy_e), .side_out(side_e)
	);

	assign {n400_e, n100_e, n4_e, hour_e, min_e, sec_e} = side_e;
	assign n1_w = n1_e[1:0];

	// leap: year % 4 == 0 unless a century year outside the 400 boundary
	assign leap_e = (n1_w == 2'd3) && ((n4_e != 5'd24) || (n100_e == 2'd3));

	// month index (from 0) = number of month starts after January at or below the day of year
	always_comb begin
		mon_e = '0;
		for (int i = 1; i < 12; i++) begin
			if (doy_e >= CUM_DAYS[leap_e][i]) begin
				mon_e = mon_e + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			leap_s17  <= leap_e;
			mon_s17   <= mon_e;
			doy_s17   <= doy_e;
			ysum_s17  <= 16'(n400_e) * 16'd400 + 16'(n100_e) * 16'd100;
			ytail_s17 <= 7'(n4_e) * 7'd4 + 7'(n1_w) + 7'd1;
			hour_s17  <= hour_e;
			min_s17   <= min_e;
			sec_s17   <= sec_e;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			year_s18  <= ysum_s17 + 16'(ytail_s17);
			month_s18 <= mon_s17 + 4'd1;
			day_s18   <= 5'(doy_s17 - CUM_DAYS[leap_s17][mon_s17] + 9'd1);
			hour_s18  <= hour_s17;
			min_s18   <= min_s17;
			sec_s18   <= sec_s17;
		end
	end

	assign m_tdata = {6'd0, sec_s18, min_s18, hour_s18, day_s18, month_s18, year_s18};

	// checks
	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (month_s18 >= 4'd1 && month_s18 <= 4'd12))
		else $error("month out of range");

	a_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (day_s18 >= 5'd1 && hour_s18 < 5'd24))
		else $error("day or hour out of range");

	a_minsec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (min_s18 < 6'd60 && sec_s18 < 6'd60))
		else $error("minute or second out of range");

	a_year: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> year_s18 >= 16'd1970)
		else $error("year before epoch");

	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

endmodule

[rtl/core/ucd_divc.sv]
// ----------------------------------------------------------------------------
// ucd_divc: pipelined division by a constant
// Reciprocal multiply, back-multiply and subtract, then one correction step
// with an optional cap on the quotient. Three stages, sideband rides along.
// ----------------------------------------------------------------------------
module ucd_divc #(
	parameter int IN_W   = 24,
	parameter int DIV    = 146097,
	parameter int Q_W    = 7,
	parameter int R_W    = 18,
	parameter int CAP    = 127,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   x,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    q,
	output logic [R_W-1:0]    r,
	output logic [SIDE_W-1:0] side_out
);

	// x < 2^K, so the floor reciprocal undershoots the quotient by at most one
	localparam int K   = IN_W;
	localparam int M_W = K - $clog2(DIV) + 1;
	localparam int P_W = IN_W + M_W;
	localparam logic [M_W-1:0] MUL   = M_W'((64'd1 << K) / 64'(DIV));
	localparam logic [R_W:0]   DIV_R = (R_W+1)'(DIV);
	localparam logic [Q_W-1:0] CAP_Q = Q_W'(CAP);

	logic [IN_W-1:0]   x_s1;
	logic [P_W-1:0]    prod_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [Q_W-1:0]    qe_s2;
	logic [R_W:0]      re_s2;
	logic [SIDE_W-1:0] side_s2;
	logic [Q_W-1:0]    q_s3;
	logic [R_W-1:0]    r_s3;
	logic [SIDE_W-1:0] side_s3;

	logic [P_W-1:0] prod_c;
	logic [Q_W-1:0] qe_c;
	logic [R_W:0]   re_c;
	logic [Q_W-1:0] qf_c;
	logic [R_W:0]   rf_c;

	// stage 1: reciprocal product
	assign prod_c = P_W'(x) * P_W'(MUL);

	// stage 2: quotient estimate and partial remainder
	assign qe_c = Q_W'(prod_s1 >> K);
	assign re_c = (R_W+1)'(x_s1 - IN_W'(qe_c) * IN_W'(DIV));

	// stage 3: fix an estimate one low, hold the quotient at its cap
	always_comb begin
		if (qe_s2 > CAP_Q) begin
			qf_c = CAP_Q;
			rf_c = re_s2 + DIV_R;
		end else if (re_s2 >= DIV_R && qe_s2 < CAP_Q) begin
			qf_c = qe_s2 + Q_W'(1);
			rf_c = re_s2 - DIV_R;
		end else begin
			qf_c = qe_s2;
			rf_c = re_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			prod_s1 <= prod_c;
			side_s1 <= side_in;
			qe_s2   <= qe_c;
			re_s2   <= re_c;
			side_s2 <= side_s1;
			q_s3    <= qf_c;
			r_s3    <= R_W'(rf_c);
			side_s3 <= side_s2;
		end
	end

	assign q        = q_s3;
	assign r        = r_s3;
	assign side_out = side_s3;

endmodule
